[hw/rtl/lognormal_density_eval_core_macros.svh]
// Assertion helpers for the lognormal density core.
// Each macro expects clk and rst in scope.
`ifndef LOGNORMAL_DENSITY_EVAL_CORE_MACROS_SVH
`define LOGNORMAL_DENSITY_EVAL_CORE_MACROS_SVH

`define LDE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lognormal density core: same-cycle check failed");

`define LDE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lognormal density core: next-cycle check failed");

`endif

[hw/rtl/lde_pkg.sv]
`default_nettype none

package lde_pkg;

  localparam int LOG_ITERS = 24;
  localparam int EXP_TERMS = 13;
  localparam int QUOT_W    = 33;
  localparam int NUM_W     = 114;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;

  localparam logic [31:0] RST_HALF_INV_VAR = 32'd32768;
  localparam logic [31:0] RST_INV_VAR      = 32'd65536;
  localparam logic [31:0] RST_INV_NORM     = 32'd26145;

  typedef enum logic [2:0] {
    REG_LOG_SHIFT    = 3'd0,
    REG_LOCATION     = 3'd1,
    REG_HALF_INV_VAR = 3'd2,
    REG_INV_VAR      = 3'd3,
    REG_INV_NORM     = 3'd4
  } cfg_reg_t;

  // Per-item flags: mode, outside the domain, result forced to zero.
  typedef struct packed {
    logic mode;
    logic dom;
    logic zero;
  } tag_t;

  typedef struct packed {
    tag_t        tag;
    logic        neg;
    logic [48:0] gmag;
    logic [63:0] dc;
  } carry_t;

  // ceil(2^36 / k); q * recip >> 36 equals q / k for any 32-bit q.
  function automatic logic [35:0] recip36(input logic [3:0] k);
    logic [35:0] r;
    case (k)
      4'd2:    r = 36'd34359738368;
      4'd3:    r = 36'd22906492246;
      4'd4:    r = 36'd17179869184;
      4'd5:    r = 36'd13743895348;
      4'd6:    r = 36'd11453246123;
      4'd7:    r = 36'd9817068106;
      4'd8:    r = 36'd8589934592;
      4'd9:    r = 36'd7635497416;
      4'd10:   r = 36'd6871947674;
      4'd11:   r = 36'd6247225158;
      4'd12:   r = 36'd5726623062;
      4'd13:   r = 36'd5286113596;
      default: r = 36'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/lognormal_density_eval_core.sv]
// Throughput: one sample per cycle; every stage is a register in one pipeline
// that advances whenever the output register is empty or being taken.
// The first stage still fills while the rest of the pipeline is held.
// Reset (rst, synchronous) clears all valid bits and loads the register defaults.
`default_nettype none

`include "lognormal_density_eval_core_macros.svh"

module lognormal_density_eval_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  input  logic [0:0]  s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [1:0]  m_tuser,   // [0] outside_domain, [1] clipped
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import lde_pkg::*;

  // ---------------- configuration ----------------
  logic [23:0] log_shift;
  logic [31:0] location, half_inv_var, inv_var, inv_norm;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_shift    <= '0;
      location     <= '0;
      half_inv_var <= RST_HALF_INV_VAR;
      inv_var      <= RST_INV_VAR;
      inv_norm     <= RST_INV_NORM;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOG_SHIFT:    log_shift    <= cfg_data[23:0];
        REG_LOCATION:     location     <= cfg_data;
        REG_HALF_INV_VAR: half_inv_var <= cfg_data;
        REG_INV_VAR:      inv_var      <= cfg_data;
        REG_INV_NORM:     inv_norm     <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic s0_v;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en || !s0_v;

  // ---------------- stage 0: d = x - theta ----------------
  logic        s0_mode;
  logic [32:0] s0_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s_tready) begin
      s0_v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s0_mode <= s_tuser[0];
      s0_d    <= {s_tdata[31], s_tdata} - {location[31], location};
    end
  end

  // ---------------- stage 1: normalize, then log2 fraction bits ----------------
  logic        lg_v    [0:LOG_ITERS];
  logic [31:0] lg_m    [0:LOG_ITERS];
  logic [23:0] lg_frac [0:LOG_ITERS];
  logic [4:0]  lg_k    [0:LOG_ITERS];
  logic [31:0] lg_d    [0:LOG_ITERS];
  tag_t        lg_tag  [0:LOG_ITERS];

  logic        s1_dom;
  logic [4:0]  s1_k;
  logic [31:0] s1_m;

  assign s1_dom = s0_d[32] || (s0_d == '0);

  always_comb begin
    s1_k = '0;
    for (int i = 0; i < 32; i++) begin
      if (s0_d[i]) begin
        s1_k = 5'(i);
      end
    end
  end

  assign s1_m = s0_d[31:0] << (5'd31 - s1_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_v[0] <= 1'b0;
    end else if (en) begin
      lg_v[0] <= s0_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_m[0]    <= s1_m;
      lg_frac[0] <= '0;
      lg_k[0]    <= s1_k;
      lg_d[0]    <= s0_d[31:0];
      lg_tag[0]  <= '{mode: s0_mode, dom: s1_dom, zero: s1_dom};
    end
  end

  // Each stage squares the Q1.31 mantissa; overflow past 2.0 is the next bit.
  for (genvar i = 0; i < LOG_ITERS; i++) begin : g_log
    logic [63:0] sq;
    logic [32:0] sh;

    assign sq = 64'(lg_m[i]) * 64'(lg_m[i]);
    assign sh = sq[63:31];

    always_ff @(posedge clk) begin
      if (rst) begin
        lg_v[i+1] <= 1'b0;
      end else if (en) begin
        lg_v[i+1] <= lg_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        lg_m[i+1]    <= sh[32] ? sh[32:1] : sh[31:0];
        lg_frac[i+1] <= {lg_frac[i][22:0], sh[32]};
        lg_k[i+1]    <= lg_k[i];
        lg_d[i+1]    <= lg_d[i];
        lg_tag[i+1]  <= lg_tag[i];
      end
    end
  end

  // ---------------- L: ln = log2 * ln2, divisor d, or d squared in mode 1 ----------------
  logic        lt_v;
  logic [60:0] lt_p;
  logic        lt_neg;
  carry_t      lt_c;

  logic [5:0]  l_ks;
  logic [29:0] l_l2, l_mag;
  logic [31:0] l_d;

  assign l_ks  = {1'b0, lg_k[LOG_ITERS]} - 6'd16;
  assign l_l2  = {l_ks, lg_frac[LOG_ITERS]};
  assign l_mag = l_l2[29] ? (30'd0 - l_l2) : l_l2;
  assign l_d   = lg_d[LOG_ITERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      lt_v <= 1'b0;
    end else if (en) begin
      lt_v <= lg_v[LOG_ITERS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lt_p   <= 61'(l_mag[28:0]) * 61'(LN2_Q32);
      lt_neg <= l_l2[29];
      lt_c   <= '{tag: lg_tag[LOG_ITERS], neg: 1'b0, gmag: 49'd1,
                  dc: lg_tag[LOG_ITERS].mode ? (64'(l_d) * 64'(l_d)) : 64'(l_d)};
    end
  end

  // ---------------- Z: round, z = ln - zeta ----------------
  logic        zt_v;
  logic [31:0] zt_az;
  logic        zt_neg;
  carry_t      zt_c;

  logic [60:0] z_rnd;
  logic [28:0] z_lnm;
  logic [33:0] z_ln, z_zeta, z_z, z_abs;

  assign z_rnd  = lt_p + 61'h0_8000_0000;
  assign z_lnm  = z_rnd[60:32];
  assign z_ln   = lt_neg ? (34'd0 - 34'(z_lnm)) : 34'(z_lnm);
  assign z_zeta = {{2{log_shift[23]}}, log_shift, 8'd0};
  assign z_z    = z_ln - z_zeta;
  assign z_abs  = z_z[33] ? (34'd0 - z_z) : z_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      zt_v <= 1'b0;
    end else if (en) begin
      zt_v <= lt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zt_az  <= z_abs[31:0];
      zt_neg <= z_z[33];
      zt_c   <= lt_c;
    end
  end

  // ---------------- Q: z squared, z * inv_var ----------------
  logic        q_v;
  logic [39:0] q_zz;
  logic [63:0] q_zvp;
  logic        q_zneg;
  carry_t      q_c;
  logic [63:0] q_sq;

  assign q_sq = 64'(zt_az) * 64'(zt_az);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
    end else if (en) begin
      q_v <= zt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_zz   <= q_sq[63:24];
      q_zvp  <= 64'(zt_az) * 64'(inv_var);
      q_zneg <= zt_neg;
      q_c    <= zt_c;
    end
  end

  // ---------------- H: zz * half_inv_var partials, derivative factor ----------------
  logic        h_v;
  logic [63:0] h_pl;
  logic [39:0] h_ph;
  carry_t      h_c;
  carry_t      h_c_next;

  logic [47:0] h_zv;
  logic [49:0] h_g, h_gabs;
  logic        h_gz;

  assign h_zv   = q_zvp[63:16];
  assign h_g    = q_zneg ? ((50'd1 << 24) - 50'(h_zv)) : ((50'd1 << 24) + 50'(h_zv));
  assign h_gabs = h_g[49] ? (50'd0 - h_g) : h_g;
  assign h_gz   = (h_g == '0);

  always_comb begin
    h_c_next = q_c;
    if (q_c.tag.mode) begin
      h_c_next.neg      = !h_g[49] && !h_gz;
      h_c_next.gmag     = h_gabs[48:0];
      h_c_next.tag.zero = q_c.tag.zero || h_gz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (en) begin
      h_v <= q_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_pl <= 64'(q_zz[31:0]) * 64'(half_inv_var);
      h_ph <= 40'(q_zz[39:32]) * 40'(half_inv_var);
      h_c  <= h_c_next;
    end
  end

  // ---------------- A: exponent argument, negligible check ----------------
  logic        a_v;
  logic [29:0] a_a;
  carry_t      a_c;
  carry_t      a_c_next;
  logic [71:0] a_prod;

  assign a_prod = 72'(h_pl) + {h_ph, 32'd0};

  // A product of 2^46 or more means an argument of 64.0 or more.
  always_comb begin
    a_c_next          = h_c;
    a_c_next.tag.zero = h_c.tag.zero || (|a_prod[71:46]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_a <= a_prod[45:16];
      a_c <= a_c_next;
    end
  end

  // ---------------- T: t = a * log2(e) ----------------
  logic        t_v;
  logic [6:0]  t_n;
  logic [23:0] t_f;
  carry_t      t_c;
  logic [62:0] t_p;

  assign t_p = 63'(a_a) * 63'(LOG2E_Q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else if (en) begin
      t_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_n <= t_p[62:56];
      t_f <= t_p[55:32];
      t_c <= a_c;
    end
  end

  // ---------------- R and exp series ----------------
  // ex_qm holds term k scaled by 2^36; ex_sum holds the sum without term k.
  logic        ex_v   [1:EXP_TERMS];
  logic [67:0] ex_qm  [1:EXP_TERMS];
  logic [34:0] ex_sum [1:EXP_TERMS];
  logic [31:0] ex_r   [1:EXP_TERMS];
  logic [7:0]  ex_s   [1:EXP_TERMS];
  carry_t      ex_c   [1:EXP_TERMS];

  logic        mu_v   [2:EXP_TERMS];
  logic [63:0] mu_p   [2:EXP_TERMS];
  logic [34:0] mu_sum [2:EXP_TERMS];
  logic [31:0] mu_r   [2:EXP_TERMS];
  logic [7:0]  mu_s   [2:EXP_TERMS];
  carry_t      mu_c   [2:EXP_TERMS];

  logic [55:0] r_p;
  assign r_p = 56'(t_f) * 56'(LN2_Q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_v[1] <= 1'b0;
    end else if (en) begin
      ex_v[1] <= t_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_qm[1]  <= {r_p[55:24], 36'd0};
      ex_sum[1] <= 35'h1_0000_0000;
      ex_r[1]   <= r_p[55:24];
      ex_s[1]   <= (t_c.tag.mode ? 8'd24 : 8'd16) + 8'(t_n);
      ex_c[1]   <= t_c;
    end
  end

  for (genvar k = 2; k <= EXP_TERMS; k++) begin : g_exp
    localparam logic [35:0] RC = recip36(4'(k));
    logic [31:0] term;
    logic [34:0] sumn;

    assign term = ex_qm[k-1][67:36];
    // Odd-numbered terms of exp(-r) are subtracted.
    assign sumn = ((k % 2) == 0) ? (ex_sum[k-1] - 35'(term)) : (ex_sum[k-1] + 35'(term));

    always_ff @(posedge clk) begin
      if (rst) begin
        mu_v[k] <= 1'b0;
        ex_v[k] <= 1'b0;
      end else if (en) begin
        mu_v[k] <= ex_v[k-1];
        ex_v[k] <= mu_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mu_p[k]   <= 64'(term) * 64'(ex_r[k-1]);
        mu_sum[k] <= sumn;
        mu_r[k]   <= ex_r[k-1];
        mu_s[k]   <= ex_s[k-1];
        mu_c[k]   <= ex_c[k-1];
        ex_qm[k]  <= 68'(mu_p[k][63:32]) * 68'(RC);
        ex_sum[k] <= mu_sum[k];
        ex_r[k]   <= mu_r[k];
        ex_s[k]   <= mu_s[k];
        ex_c[k]   <= mu_c[k];
      end
    end
  end

  // ---------------- P: em * inv_norm ----------------
  logic        p_v;
  logic [64:0] p_p;
  logic [7:0]  p_s;
  carry_t      p_c;
  logic [34:0] p_em;

  assign p_em = ex_sum[EXP_TERMS] - 35'(ex_qm[EXP_TERMS][67:36]);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (en) begin
      p_v <= ex_v[EXP_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_p <= 65'(p_em[32:0]) * 65'(inv_norm);
      p_s <= ex_s[EXP_TERMS];
      p_c <= ex_c[EXP_TERMS];
    end
  end

  // ---------------- N1/N2/N3: numerator = p * |g| ----------------
  logic        n1_v;
  logic [57:0] n1_00;
  logic [56:0] n1_01, n1_10;
  logic [55:0] n1_11;
  logic [7:0]  n1_s;
  carry_t      n1_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_v <= 1'b0;
    end else if (en) begin
      n1_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_00 <= 58'(p_p[32:0]) * 58'(p_c.gmag[24:0]);
      n1_01 <= 57'(p_p[32:0]) * 57'(p_c.gmag[48:25]);
      n1_10 <= 57'(p_p[64:33]) * 57'(p_c.gmag[24:0]);
      n1_11 <= 56'(p_p[64:33]) * 56'(p_c.gmag[48:25]);
      n1_s  <= p_s;
      n1_c  <= p_c;
    end
  end

  logic             n2_v;
  logic [NUM_W-1:0] n2_a, n2_b;
  logic [7:0]       n2_s;
  carry_t           n2_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      n2_v <= 1'b0;
    end else if (en) begin
      n2_v <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2_a <= NUM_W'(n1_00) + (NUM_W'(n1_01) << 25);
      n2_b <= NUM_W'(n1_10) + (NUM_W'(n1_11) << 25);
      n2_s <= n1_s;
      n2_c <= n1_c;
    end
  end

  logic             n3_v;
  logic [NUM_W-1:0] n3_n;
  logic [7:0]       n3_s;
  carry_t           n3_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      n3_v <= 1'b0;
    end else if (en) begin
      n3_v <= n2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_n <= n2_a + (n2_b << 33);
      n3_s <= n2_s;
      n3_c <= n2_c;
    end
  end

  // ---------------- SH: drop the power-of-two scale ----------------
  logic             sh_v;
  logic [NUM_W-1:0] sh_n;
  carry_t           sh_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_v <= 1'b0;
    end else if (en) begin
      sh_v <= n3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_n <= n3_n >> n3_s;
      sh_c <= n3_c;
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic        dv_v   [0:QUOT_W];
  logic [63:0] dv_r   [0:QUOT_W];
  logic [32:0] dv_q   [0:QUOT_W];
  logic        dv_ovf [0:QUOT_W];
  carry_t      dv_c   [0:QUOT_W];

  logic [80:0] di_hi;
  assign di_hi = sh_n[NUM_W-1:33];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (en) begin
      dv_v[0] <= sh_v;
    end
  end

  // A quotient of 2^33 or more saturates anyway.
  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0]   <= di_hi[63:0];
      dv_q[0]   <= sh_n[32:0];
      dv_ovf[0] <= di_hi >= 81'(sh_c.dc);
      dv_c[0]   <= sh_c;
    end
  end

  for (genvar i = 0; i < QUOT_W; i++) begin : g_div
    logic [64:0] rx;
    logic        ge;

    assign rx = {dv_r[i], dv_q[i][32]};
    assign ge = rx >= {1'b0, dv_c[i].dc};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[i+1] <= 1'b0;
      end else if (en) begin
        dv_v[i+1] <= dv_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[i+1]   <= ge ? 64'(rx - {1'b0, dv_c[i].dc}) : rx[63:0];
        dv_q[i+1]   <= {dv_q[i][31:0], ge};
        dv_ovf[i+1] <= dv_ovf[i];
        dv_c[i+1]   <= dv_c[i];
      end
    end
  end

  // ---------------- output: cap, sign, saturate ----------------
  logic [32:0] o_q, o_mag;
  logic [31:0] o_val;
  logic        o_clip, o_dom;
  carry_t      o_c;

  assign o_q = dv_q[QUOT_W];
  assign o_c = dv_c[QUOT_W];
  assign o_mag = (dv_ovf[QUOT_W] || (o_q[32] && (|o_q[31:0]))) ? 33'h1_0000_0000 : o_q;

  always_comb begin
    o_val  = '0;
    o_clip = 1'b0;
    o_dom  = o_c.tag.dom;
    if (o_c.tag.dom || o_c.tag.zero) begin
      o_val = '0;
    end else if (o_c.neg) begin
      if (o_mag > 33'h0_8000_0000) begin
        o_val  = 32'h8000_0000;
        o_clip = 1'b1;
      end else begin
        o_val = 32'd0 - o_mag[31:0];
      end
    end else begin
      if (o_mag > 33'h0_7FFF_FFFF) begin
        o_val  = 32'h7FFF_FFFF;
        o_clip = 1'b1;
      end else begin
        o_val = o_mag[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= dv_v[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= o_val;
      m_tuser <= {o_clip, o_dom};
    end
  end

  // ---------------- checks ----------------
  `LDE_ASSERT_IMP(a_dom_gives_zero, m_tvalid && m_tuser[0], m_tdata == 32'd0 && !m_tuser[1])
  `LDE_ASSERT_IMP(a_clip_on_rail, m_tvalid && m_tuser[1], m_tdata[30:0] == {31{!m_tdata[31]}})
  `LDE_ASSERT_NXT(a_fill_while_held, !en && !s0_v && s_tvalid, s0_v)
  `LDE_ASSERT_NXT(a_hold_on_stall, m_tvalid && !m_tready && lg_v[0], lg_v[0])

endmodule

`default_nettype wire
